// File: src/speed_to_pwm_interpolator_core_defines.svh
// assertion macros used by the interpolator core rtl
`ifndef SPEED_TO_PWM_INTERPOLATOR_CORE_DEFINES_SVH
`define SPEED_TO_PWM_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication on clk, disabled while arst_n is low
`define STPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled while arst_n is low
`define STPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/stpi_pkg.sv
// types, constants and microcode rom of the speed to pwm interpolator
package stpi_pkg;

	localparam int SPEED_W = 16;
	localparam int DSPEED_W = 17;
	localparam int PWM_W = 8;
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_Q_W = 8;
	localparam int DIV_CNT_W = 3;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int COUNT_W = 4;

	// speed in cm/s divided by ten is raw q8.8 divided by 2560, that is (raw >> 9) / 5,
	// taken as ((raw >> 9) * 205) >> 10, exact for every 7-bit shifted value
	localparam logic [7:0] UNCAL_RECIP = 8'd205;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic MOTOR_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		REG_LEFT_COUNT  = 2'd0,
		REG_RIGHT_COUNT = 2'd1,
		REG_CALIBRATED  = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE    = 5'd0,
		S_START   = 5'd1,
		S_UNCAL   = 5'd2,
		S_MAXRD   = 5'd3,
		S_MAXUPD  = 5'd4,
		S_CLAMP   = 5'd5,
		S_RD0     = 5'd6,
		S_FIRST   = 5'd7,
		S_SEGRD   = 5'd8,
		S_SEGTST  = 5'd9,
		S_SEGHIT  = 5'd10,
		S_DIVINIT = 5'd11,
		S_DIVSTEP = 5'd12,
		S_DIVFIN  = 5'd13,
		S_RZERO   = 5'd14,
		S_RCUR    = 5'd15,
		S_RPREV   = 5'd16,
		S_OUT     = 5'd17,
		S_DONE    = 5'd18
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLR,
		OP_DIV_UNCAL,
		OP_RD,
		OP_MAX,
		OP_CLAMP,
		OP_LOAD_CUR,
		OP_RD_SHIFT,
		OP_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_RES_DIV,
		OP_RES_ZERO,
		OP_RES_CUR,
		OP_RES_PREV,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_QUERY,
		C_CAL,
		C_I_END,
		C_CNT_ZERO,
		C_D_LE_RD,
		C_OUT_SEG,
		C_FLAT,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// one control word per step: taken jump goes to target, else to the next step
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t uw;
		case (pc)
			S_IDLE:    uw = '{OP_NOP,       C_NO_QUERY, S_IDLE};
			S_START:   uw = '{OP_CLR,       C_CAL,      S_MAXRD};
			S_UNCAL:   uw = '{OP_DIV_UNCAL, C_ALWAYS,   S_OUT};
			S_MAXRD:   uw = '{OP_RD,        C_I_END,    S_CLAMP};
			S_MAXUPD:  uw = '{OP_MAX,       C_ALWAYS,   S_MAXRD};
			S_CLAMP:   uw = '{OP_CLAMP,     C_CNT_ZERO, S_RZERO};
			S_RD0:     uw = '{OP_RD,        C_NEVER,    S_IDLE};
			S_FIRST:   uw = '{OP_LOAD_CUR,  C_D_LE_RD,  S_RCUR};
			S_SEGRD:   uw = '{OP_RD_SHIFT,  C_I_END,    S_RCUR};
			S_SEGTST:  uw = '{OP_LOAD_CUR,  C_OUT_SEG,  S_SEGRD};
			S_SEGHIT:  uw = '{OP_MUL,       C_FLAT,     S_RPREV};
			S_DIVINIT: uw = '{OP_DIV_INIT,  C_NEVER,    S_IDLE};
			S_DIVSTEP: uw = '{OP_DIV_STEP,  C_DIV_MORE, S_DIVSTEP};
			S_DIVFIN:  uw = '{OP_RES_DIV,   C_ALWAYS,   S_OUT};
			S_RZERO:   uw = '{OP_RES_ZERO,  C_ALWAYS,   S_OUT};
			S_RCUR:    uw = '{OP_RES_CUR,   C_ALWAYS,   S_OUT};
			S_RPREV:   uw = '{OP_RES_PREV,  C_NEVER,    S_IDLE};
			S_OUT:     uw = '{OP_OUT,       C_OUT_BUSY, S_OUT};
			S_DONE:    uw = '{OP_NOP,       C_ALWAYS,   S_IDLE};
			default:   uw = '{OP_NOP,       C_ALWAYS,   S_IDLE};
		endcase
		return uw;
	endfunction

endpackage

// File: src/stpi_stream_ifs.sv
// valid/ready channels for request and response transactions
interface stpi_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic                                motor_sel;
	logic [2:0]                          point_index;
	logic [stpi_pkg::PWM_W-1:0]          point_pwm;
	logic [stpi_pkg::SPEED_W-1:0]        point_speed;
	logic signed [stpi_pkg::DSPEED_W-1:0] desired_speed;

	modport source (
		output valid, req_type, motor_sel, point_index, point_pwm, point_speed,
			desired_speed,
		input ready
	);
	modport sink (
		input valid, req_type, motor_sel, point_index, point_pwm, point_speed,
			desired_speed,
		output ready
	);
endinterface

interface stpi_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [stpi_pkg::PWM_W-1:0] pwm_value;

	modport source (output valid, pwm_value, input ready);
	modport sink (input valid, pwm_value, output ready);
endinterface

// File: src/speed_to_pwm_interpolator_core.sv
// load transaction written in its accept cycle; uncalibrated query passes the start, uncal and
// output steps; calibrated query time is set by the max and segment scans of the table (on the
// single registered read port) and by the 8-step divider
// throughput: one query at a time; next transaction taken once the sequencer has passed the done
// step back to idle after the result registers, also while that result waits
// reset: asynchronous active low, clears sequencer, output valid and config; tables not cleared
`include "speed_to_pwm_interpolator_core_defines.svh"

module speed_to_pwm_interpolator_core #(
	parameter int MAX_POINTS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	stpi_req_if.sink                           req,
	stpi_rsp_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stpi_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [stpi_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [stpi_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam int DEPTH = 2 * MAX_POINTS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_POINTS + 1);

	// configuration
	logic [stpi_pkg::COUNT_W-1:0] left_count_q;
	logic [stpi_pkg::COUNT_W-1:0] right_count_q;
	logic                         calibrated_q;
	logic                         cfg_wr;

	// sequencer
	stpi_pkg::step_t  pc_q;
	stpi_pkg::step_t  pc_nxt;
	stpi_pkg::ucode_t uw;
	logic             jump;

	// datapath
	logic                                motor_q;
	logic signed [stpi_pkg::DSPEED_W-1:0] desired_q;
	logic [CW-1:0]                       cnt_q;
	logic [CW-1:0]                       i_q;
	logic [stpi_pkg::SPEED_W-1:0]        maxs_q;
	logic [stpi_pkg::SPEED_W-1:0]        d_q;
	logic [stpi_pkg::SPEED_W-1:0]        prev_s_q;
	logic [stpi_pkg::PWM_W-1:0]          prev_p_q;
	logic [stpi_pkg::SPEED_W-1:0]        cur_s_q;
	logic [stpi_pkg::PWM_W-1:0]          cur_p_q;
	logic [stpi_pkg::DIV_NUM_W-1:0]      prod_q;
	logic                                neg_q;
	logic [stpi_pkg::PWM_W-1:0]          base_q;
	logic [stpi_pkg::PWM_W-1:0]          res_q;
	logic                                out_valid_q;
	logic [stpi_pkg::PWM_W-1:0]          out_pwm_q;

	// table memory
	logic [stpi_pkg::PWM_W-1:0]   pwm_mem [DEPTH];
	logic [stpi_pkg::SPEED_W-1:0] spd_mem [DEPTH];
	logic [stpi_pkg::PWM_W-1:0]   rd_pwm_q;
	logic [stpi_pkg::SPEED_W-1:0] rd_spd_q;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;

	logic                         req_fire;
	logic                         query_fire;
	logic                         out_busy;
	logic [stpi_pkg::COUNT_W-1:0] cnt_raw;
	logic [CW-1:0]                cnt_sel;
	logic [stpi_pkg::PWM_W-1:0]   pdiff;
	logic [stpi_pkg::SPEED_W-1:0] sdiff;
	logic [14:0]                  uncal_prod;

	stpi_pkg::div_ctl_t               div_ctl;
	logic [stpi_pkg::DIV_NUM_W-1:0]   div_num;
	logic [stpi_pkg::DIV_DEN_W-1:0]   div_den;
	logic [stpi_pkg::DIV_Q_W-1:0]     div_quo;
	logic                             div_rem_nz;
	logic                             div_last;

	// apb configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q <= '0;
			right_count_q <= '0;
			calibrated_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				stpi_pkg::REG_LEFT_COUNT:  left_count_q <= pwdata[stpi_pkg::COUNT_W-1:0];
				stpi_pkg::REG_RIGHT_COUNT: right_count_q <= pwdata[stpi_pkg::COUNT_W-1:0];
				stpi_pkg::REG_CALIBRATED:  calibrated_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			stpi_pkg::REG_LEFT_COUNT:  prdata = {28'b0, left_count_q};
			stpi_pkg::REG_RIGHT_COUNT: prdata = {28'b0, right_count_q};
			stpi_pkg::REG_CALIBRATED:  prdata = {31'b0, calibrated_q};
			default:                   prdata = '0;
		endcase
	end

	// request channel
	assign req.ready = pc_q == stpi_pkg::S_IDLE;
	assign req_fire = req.valid && req.ready;
	assign query_fire = req_fire && req.req_type == stpi_pkg::REQ_QUERY;

	assign cnt_raw = (req.motor_sel == stpi_pkg::MOTOR_RIGHT) ? right_count_q : left_count_q;
	assign cnt_sel = (32'(cnt_raw) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cnt_raw);

	// microcode sequencer
	assign uw = stpi_pkg::ucode_rom(pc_q);
	assign out_busy = out_valid_q && !rsp.ready;

	always_comb begin
		case (uw.cond)
			stpi_pkg::C_NEVER:    jump = 1'b0;
			stpi_pkg::C_ALWAYS:   jump = 1'b1;
			stpi_pkg::C_NO_QUERY: jump = !query_fire;
			stpi_pkg::C_CAL:      jump = calibrated_q;
			stpi_pkg::C_I_END:    jump = i_q == cnt_q;
			stpi_pkg::C_CNT_ZERO: jump = cnt_q == '0;
			stpi_pkg::C_D_LE_RD:  jump = d_q <= rd_spd_q;
			stpi_pkg::C_OUT_SEG:  jump = !(d_q >= prev_s_q && d_q <= rd_spd_q);
			stpi_pkg::C_FLAT:     jump = prev_s_q == cur_s_q;
			stpi_pkg::C_DIV_MORE: jump = !div_last;
			stpi_pkg::C_OUT_BUSY: jump = out_busy;
			default:              jump = 1'b0;
		endcase
		pc_nxt = jump ? uw.target : stpi_pkg::step_t'(pc_q + 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= stpi_pkg::S_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// table memory: load writes in the accept cycle, reads are registered
	assign wr_en = req_fire && req.req_type == stpi_pkg::REQ_LOAD
		&& 32'(req.point_index) < MAX_POINTS;
	assign wr_addr = ((req.motor_sel == stpi_pkg::MOTOR_RIGHT) ? AW'(MAX_POINTS) : AW'(0))
		+ AW'(req.point_index);
	assign rd_en = (uw.op == stpi_pkg::OP_RD || uw.op == stpi_pkg::OP_RD_SHIFT) && i_q != cnt_q;
	assign rd_addr = (motor_q ? AW'(MAX_POINTS) : AW'(0)) + AW'(i_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pwm_mem[wr_addr] <= req.point_pwm;
			spd_mem[wr_addr] <= req.point_speed;
		end
		if (rd_en) begin
			rd_pwm_q <= pwm_mem[rd_addr];
			rd_spd_q <= spd_mem[rd_addr];
		end
	end

	// interpolation datapath
	assign pdiff = (cur_p_q >= prev_p_q) ? cur_p_q - prev_p_q : prev_p_q - cur_p_q;
	assign sdiff = d_q - prev_s_q;
	// uncalibrated speed / 2560 by reciprocal multiply of the speed shifted down by 9
	assign uncal_prod = {8'b0, desired_q[stpi_pkg::SPEED_W-1:9]} * {7'b0, stpi_pkg::UNCAL_RECIP};

	always_ff @(posedge clk) begin
		if (query_fire) begin
			motor_q <= req.motor_sel;
			desired_q <= req.desired_speed;
			cnt_q <= cnt_sel;
		end
		case (uw.op)
			stpi_pkg::OP_CLR: begin
				i_q <= '0;
				maxs_q <= '0;
			end
			stpi_pkg::OP_DIV_UNCAL: begin
				res_q <= desired_q[stpi_pkg::DSPEED_W-1] ? '0 : {3'b0, uncal_prod[14:10]};
			end
			stpi_pkg::OP_RD: begin
				if (rd_en) begin
					i_q <= i_q + 1'b1;
				end
			end
			stpi_pkg::OP_MAX: begin
				if (rd_spd_q > maxs_q) begin
					maxs_q <= rd_spd_q;
				end
			end
			stpi_pkg::OP_CLAMP: begin
				i_q <= '0;
				if (desired_q[stpi_pkg::DSPEED_W-1]) begin
					d_q <= '0;
				end else if (desired_q[stpi_pkg::SPEED_W-1:0] > maxs_q) begin
					d_q <= maxs_q;
				end else begin
					d_q <= desired_q[stpi_pkg::SPEED_W-1:0];
				end
			end
			stpi_pkg::OP_LOAD_CUR: begin
				cur_s_q <= rd_spd_q;
				cur_p_q <= rd_pwm_q;
			end
			stpi_pkg::OP_RD_SHIFT: begin
				prev_s_q <= cur_s_q;
				prev_p_q <= cur_p_q;
				if (rd_en) begin
					i_q <= i_q + 1'b1;
				end
			end
			stpi_pkg::OP_MUL: begin
				prod_q <= {8'b0, sdiff} * {16'b0, pdiff};
				neg_q <= cur_p_q < prev_p_q;
				base_q <= prev_p_q;
			end
			// falling segment rounds toward minus infinity
			stpi_pkg::OP_RES_DIV: begin
				res_q <= neg_q ? base_q - div_quo - {7'b0, div_rem_nz} : base_q + div_quo;
			end
			stpi_pkg::OP_RES_ZERO: res_q <= '0;
			stpi_pkg::OP_RES_CUR:  res_q <= cur_p_q;
			stpi_pkg::OP_RES_PREV: res_q <= prev_p_q;
			default: ;
		endcase
	end

	// serial divider
	assign div_ctl.load = uw.op == stpi_pkg::OP_DIV_INIT;
	assign div_ctl.step = uw.op == stpi_pkg::OP_DIV_STEP;
	assign div_num = prod_q;
	assign div_den = cur_s_q - prev_s_q;

	stpi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem_nz (div_rem_nz),
		.last   (div_last)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == stpi_pkg::OP_OUT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == stpi_pkg::OP_OUT && !out_busy) begin
			out_pwm_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.pwm_value = out_pwm_q;

	`STPI_ASSERT_NXT(a_query_starts, query_fire, pc_q == stpi_pkg::S_START, "query not started")
	`STPI_ASSERT_IMP(a_rsp_from_out, $rose(out_valid_q), $past(pc_q) == stpi_pkg::S_OUT, "response outside output step")
	`STPI_ASSERT_NXT(a_div_exit, pc_q == stpi_pkg::S_DIVSTEP && div_last, pc_q == stpi_pkg::S_DIVFIN, "divider exit missed")

endmodule

// File: src/stpi_divider.sv
// restoring divider, one quotient bit per step, quotient known to fit in eight bits
module stpi_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stpi_pkg::div_ctl_t                ctl,
	input  logic [stpi_pkg::DIV_NUM_W-1:0]    num,
	input  logic [stpi_pkg::DIV_DEN_W-1:0]    den,
	output logic [stpi_pkg::DIV_Q_W-1:0]      quo,
	output logic                              rem_nz,
	output logic                              last
);

	logic [stpi_pkg::DIV_NUM_W-1:0] rem_q;
	logic [stpi_pkg::DIV_NUM_W-1:0] den_q;
	logic [stpi_pkg::DIV_Q_W-1:0]   quo_q;
	logic [stpi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           ge;

	assign ge = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '1;
		end else if (ctl.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// divisor starts aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= num;
			den_q <= {1'b0, den, 7'b0};
			quo_q <= '0;
		end else if (ctl.step) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[stpi_pkg::DIV_Q_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign quo = quo_q;
	assign rem_nz = rem_q != '0;
	assign last = cnt_q == '0;

endmodule
